// ----- src/qem_pkg.sv -----
// Shared types and constants of the quantized element-wise multiplier.
// No dependencies; every other file of the block imports this package.
package qem_pkg;

  localparam int ZP_W       = 8;   // zero points and broadcast operand
  localparam int ACC_W      = 32;  // accumulator and result width
  localparam int MULT_W     = 31;  // Q31 requantization multiplier
  localparam int SHIFT_W    = 6;   // signed shift amount
  localparam int PROD_W     = 63;  // accumulator times multiplier, exact
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [MULT_W-1:0] MULT_RESET = MULT_W'(32'h4000_0000);

  // Rounding nudge added before the arithmetic shift right by 31.
  localparam logic [63:0] NUDGE_POS = 64'h0000_0000_4000_0000;
  localparam logic [63:0] NUDGE_NEG = 64'hFFFF_FFFF_C000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZERO_POINT_A      = 3'd0,
    REG_ZERO_POINT_B      = 3'd1,
    REG_ZERO_POINT_OUT    = 3'd2,
    REG_MULTIPLIER_Q31    = 3'd3,
    REG_SHIFT_AMOUNT      = 3'd4,
    REG_BROADCAST_MODE    = 3'd5,
    REG_BROADCAST_OPERAND = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [ZP_W-1:0]    zero_point_a;
    logic signed [ZP_W-1:0]    zero_point_b;
    logic signed [ZP_W-1:0]    zero_point_out;
    logic        [MULT_W-1:0]  multiplier_q31;
    logic signed [SHIFT_W-1:0] shift_amount;
    logic                      broadcast_mode;
    logic signed [ZP_W-1:0]    broadcast_operand;
  } cfg_t;

endpackage

// ----- src/qem_if.sv -----
// Valid/ready channel interfaces of the quantized element-wise multiplier:
// operand input, result output and configuration write. Depends on qem_pkg.
interface qem_in_if #(
  parameter int OPERAND_BITS = 8
);
  logic                           valid;
  logic                           ready;
  logic signed [OPERAND_BITS-1:0] operand_a;
  logic signed [OPERAND_BITS-1:0] operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface qem_out_if
  import qem_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] product_out;

  modport source (output valid, output product_out, input ready);
  modport sink   (input valid, input product_out, output ready);
endinterface

interface qem_cfg_if
  import qem_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/quantized_elementwise_multiply.sv -----
// Top level of the quantized element-wise multiplier with requantization.
// Depends on qem_pkg, the channel interfaces, qem_cfg, qem_product,
// qem_scale and qem_requant.
//
// Usage:
//   in_i   carries one word per element: operand_a and operand_b, signed.
//          operand_b is ignored while broadcast mode is set.
//   out_o  returns one word per input word, in order: product_out, the
//          requantized product plus the output zero point, wrapping at
//          32 bits.
//   cfg_i  writes one register per word (index, data); it is always ready.
//          Write registers only while no words are in flight.
// From acceptance to product_out valid a word passes four register stages:
// operand multiply, Q31 multiply, shift/nudge, rounding shift/zero point.
// A new word is taken every cycle unless all stages are full and stalled.
// When the receiver holds ready low, words stay in their stages and empty
// stages keep filling; in_i.ready drops once all four stages are full.
// Reset empties the pipeline and sets all registers to their defaults
// (multiplier 2^30, everything else zero).
module quantized_elementwise_multiply
  import qem_pkg::*;
#(
  parameter int OPERAND_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qem_in_if.sink     in_i,
  qem_out_if.source  out_o,
  qem_cfg_if.sink    cfg_i
);

  cfg_t                     cfg;
  logic                     s1_valid;
  logic                     s1_ready;
  logic signed [ACC_W-1:0]  s1_acc;
  logic                     s2_valid;
  logic                     s2_ready;
  logic signed [PROD_W-1:0] s2_prod;
  logic signed [ACC_W-1:0]  result;

  qem_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  qem_product #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_product (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (in_i.valid),
    .ready_o     (in_i.ready),
    .operand_a_i (in_i.operand_a),
    .operand_b_i (in_i.operand_b),
    .valid_o     (s1_valid),
    .ready_i     (s1_ready),
    .acc_o       (s1_acc)
  );

  qem_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .acc_i   (s1_acc),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .prod_o  (s2_prod)
  );

  qem_requant u_requant (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (s2_valid),
    .ready_o  (s2_ready),
    .prod_i   (s2_prod),
    .valid_o  (out_o.valid),
    .ready_i  (out_o.ready),
    .result_o (result)
  );

  assign out_o.product_out = result;

endmodule

// ----- src/qem_cfg.sv -----
// Configuration register file of the quantized element-wise multiplier.
// Depends on qem_pkg and qem_cfg_if.
module qem_cfg
  import qem_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  qem_cfg_if.sink      cfg_i,
  output cfg_t         cfg_o
);

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_point_a      <= '0;
      cfg_q.zero_point_b      <= '0;
      cfg_q.zero_point_out    <= '0;
      cfg_q.multiplier_q31    <= MULT_RESET;
      cfg_q.shift_amount      <= '0;
      cfg_q.broadcast_mode    <= 1'b0;
      cfg_q.broadcast_operand <= '0;
    end else if (cfg_i.valid) begin
      // Writes to an index outside the register list are dropped.
      unique case (cfg_reg_e'(cfg_i.index))
        REG_ZERO_POINT_A:      cfg_q.zero_point_a      <= cfg_i.data[ZP_W-1:0];
        REG_ZERO_POINT_B:      cfg_q.zero_point_b      <= cfg_i.data[ZP_W-1:0];
        REG_ZERO_POINT_OUT:    cfg_q.zero_point_out    <= cfg_i.data[ZP_W-1:0];
        REG_MULTIPLIER_Q31:    cfg_q.multiplier_q31    <= cfg_i.data[MULT_W-1:0];
        REG_SHIFT_AMOUNT:      cfg_q.shift_amount      <= cfg_i.data[SHIFT_W-1:0];
        REG_BROADCAST_MODE:    cfg_q.broadcast_mode    <= cfg_i.data[0];
        REG_BROADCAST_OPERAND: cfg_q.broadcast_operand <= cfg_i.data[ZP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- src/qem_product.sv -----
// First pipeline stage: zero-point removal and the operand multiply,
// kept as a 32-bit signed accumulator. Depends on qem_pkg.
module qem_product
  import qem_pkg::*;
#(
  parameter int OPERAND_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cfg_t                           cfg_i,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [OPERAND_BITS-1:0] operand_a_i,
  input  logic signed [OPERAND_BITS-1:0] operand_b_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic signed [ACC_W-1:0]        acc_o
);

  // Difference width: widest of operand and zero point, plus one bit.
  localparam int DW = ((OPERAND_BITS > ZP_W) ? OPERAND_BITS : ZP_W) + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0]    a_ext;
  logic signed [DW-1:0]    b_ext;
  logic signed [DW-1:0]    diff_a;
  logic signed [DW-1:0]    diff_b;
  logic signed [PW-1:0]    prod;
  logic signed [ACC_W-1:0] acc_d;
  logic signed [ACC_W-1:0] acc_q;
  logic                    valid_q;

  assign a_ext  = DW'(operand_a_i);
  assign b_ext  = cfg_i.broadcast_mode ? DW'($signed(cfg_i.broadcast_operand))
                                       : DW'(operand_b_i);
  assign diff_a = a_ext - DW'($signed(cfg_i.zero_point_a));
  assign diff_b = b_ext - DW'($signed(cfg_i.zero_point_b));
  assign prod   = diff_a * diff_b;

  generate
    if (PW >= ACC_W) begin : g_trunc
      assign acc_d = prod[ACC_W-1:0];
    end else begin : g_sext
      assign acc_d = {{(ACC_W-PW){prod[PW-1]}}, prod};
    end
  endgenerate

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign acc_o   = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      acc_q <= acc_d;
    end
  end

endmodule

// ----- src/qem_scale.sv -----
// Second pipeline stage: accumulator times the Q31 multiplier, exact to
// 63 bits. Depends on qem_pkg.
module qem_scale
  import qem_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic signed [ACC_W-1:0]  acc_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [63:0]       full;
  logic signed [PROD_W-1:0] prod_q;
  logic                     valid_q;

  // A signed 32-bit value times a non-negative 31-bit value always fits
  // in 63 bits, so the upper bit of the full product is dropped.
  assign full    = acc_i * $signed({1'b0, cfg_i.multiplier_q31});

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign prod_o  = prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      prod_q <= full[PROD_W-1:0];
    end
  end

endmodule

// ----- src/qem_requant.sv -----
// Third and fourth pipeline stages: left shift, nudge and high-word pick,
// then the rounding right shift and output zero point. Depends on qem_pkg.
module qem_requant
  import qem_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic signed [PROD_W-1:0] prod_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic signed [ACC_W-1:0]  result_o
);

  logic [SHIFT_W-2:0]      left;
  logic [SHIFT_W-1:0]      right;
  logic [63:0]             shifted;
  logic [63:0]             nudged;
  logic [ACC_W-1:0]        high_d;
  logic [ACC_W-1:0]        high_q;
  logic                    valid3_q;
  logic                    ready3;
  logic signed [ACC_W:0]   high_ext;
  logic signed [ACC_W:0]   asr;
  logic [ACC_W:0]          mask;
  logic [ACC_W:0]          rem;
  logic [ACC_W:0]          thr;
  logic                    round_up;
  logic [ACC_W-1:0]        rounded;
  logic [ACC_W-1:0]        result_d;
  logic [ACC_W-1:0]        result_q;
  logic                    valid4_q;

  // A negative shift amount selects the rounding right shift (1 to 32).
  assign left  = cfg_i.shift_amount[SHIFT_W-1] ? '0
                                               : cfg_i.shift_amount[SHIFT_W-2:0];
  assign right = cfg_i.shift_amount[SHIFT_W-1] ? SHIFT_W'(~cfg_i.shift_amount + 1'b1)
                                               : '0;

  // Stage 3: the product is taken modulo 2^64 after the left shift, and
  // its sign there picks the nudge direction.
  assign shifted = {prod_i[PROD_W-1], prod_i} << left;
  assign nudged  = shifted + (shifted[63] ? NUDGE_NEG : NUDGE_POS);
  assign high_d  = nudged[62:31];

  // Stage 4: round half away from zero; with no right shift the mask is
  // empty and the value passes unchanged.
  assign high_ext = $signed({high_q[ACC_W-1], high_q});
  assign asr      = high_ext >>> right;
  assign mask     = ((ACC_W+1)'(1) << right) - (ACC_W+1)'(1);
  assign rem      = high_ext & mask;
  assign thr      = (mask >> 1) + (ACC_W+1)'(high_q[ACC_W-1]);
  assign round_up = rem > thr;
  assign rounded  = asr[ACC_W-1:0] + ACC_W'(round_up);
  assign result_d = rounded + ACC_W'($signed(cfg_i.zero_point_out));

  assign ready3   = !valid4_q || ready_i;
  assign ready_o  = !valid3_q || ready3;
  assign valid_o  = valid4_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else begin
      if (ready_o) begin
        valid3_q <= valid_i;
      end
      if (ready3) begin
        valid4_q <= valid3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      high_q <= high_d;
    end
    if (ready3 && valid3_q) begin
      result_q <= result_d;
    end
  end

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for quantized_elementwise_multiply: directed table, then random
// phases of register settings and operand streams with random stalls on both channels.
// Depends on qem_pkg, the qem channel interfaces and the block's RTL.
`timescale 1ns / 1ps

module testbench;
  import qem_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam int PHASES          = 14;
  localparam int WORDS_PER_PHASE = 125;
  localparam int STEADY_PHASE    = 5;
  localparam int DRAIN_CYCLES    = 8;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    logic signed [7:0]     op_a;
    logic signed [7:0]     op_b;
    logic                  typed;
    logic [ACC_W-1:0]      result;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  qem_in_if #(.OPERAND_BITS(8)) in_ch ();
  qem_out_if                    out_ch ();
  qem_cfg_if                    cfg_ch ();

  quantized_elementwise_multiply #(.OPERAND_BITS(8)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  cfg_t             active_cfg;
  logic [ACC_W-1:0] pending_products[$];
  stim_row_t        directed_rows[$];
  int               mismatch_count = 0;
  bit               no_idle_stretch = 1'b0;

  always #4 clk_i = ~clk_i;

  // Zero points are subtracted, the product is scaled by the Q31 multiplier with a
  // sign-dependent nudge, then rounded half away from zero for negative shifts.
  function automatic logic [ACC_W-1:0] requantized_product(logic signed [7:0] op_a,
                                                           logic signed [7:0] op_b);
    logic signed [63:0] a64, b64, za, zb, zo;
    logic [63:0] acc, wide, sum, high, mask, rem, limit;
    logic [63:0] raw;
    int shift, left, right;
    a64 = 64'(op_a);
    if (active_cfg.broadcast_mode) b64 = 64'(active_cfg.broadcast_operand);
    else b64 = 64'(op_b);
    za = 64'(active_cfg.zero_point_a);
    zb = 64'(active_cfg.zero_point_b);
    zo = 64'(active_cfg.zero_point_out);
    raw = (a64 - za) * (b64 - zb);
    acc = {{32{raw[31]}}, raw[31:0]};
    shift = int'(active_cfg.shift_amount);
    left  = (shift >= 0) ? shift : 0;
    right = (shift < 0) ? -shift : 0;
    wide = (acc << left) * {33'd0, active_cfg.multiplier_q31};
    sum  = wide + (wide[63] ? NUDGE_NEG : NUDGE_POS);
    high = {{32{sum[62]}}, sum[62:31]};
    if (right != 0) begin
      mask  = (64'd1 << right) - 64'd1;
      rem   = high & mask;
      limit = (mask >> 1) + {63'd0, high[63]};
      high  = $unsigned($signed(high) >>> right) + ((rem > limit) ? 64'd1 : 64'd0);
    end
    return ACC_W'(high + zo);
  endfunction

  function automatic logic signed [7:0] random_operand();
    logic signed [7:0] value;
    value = 8'($urandom);
    if ($urandom_range(7) == 0) value = $urandom_range(1) ? 8'sh7F : 8'sh80;
    return value;
  endfunction

  function automatic stim_row_t write_row(logic [CFG_IDX_W-1:0] index,
                                          logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '0;
    row.kind  = ROW_WRITE;
    row.index = index;
    row.data  = data;
    return row;
  endfunction

  function automatic stim_row_t item_row(int op_a, int op_b);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.op_a = 8'(op_a);
    row.op_b = 8'(op_b);
    return row;
  endfunction

  function automatic stim_row_t checked_row(int op_a, int op_b, logic [ACC_W-1:0] result);
    stim_row_t row;
    row = item_row(op_a, op_b);
    row.typed  = 1'b1;
    row.result = result;
    return row;
  endfunction

  // Registers change only with nothing in flight; cfg valid stays high across
  // back-to-back writes and is lowered by the next operand word.
  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    in_ch.valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (index)
      REG_ZERO_POINT_A:      active_cfg.zero_point_a      = data[ZP_W-1:0];
      REG_ZERO_POINT_B:      active_cfg.zero_point_b      = data[ZP_W-1:0];
      REG_ZERO_POINT_OUT:    active_cfg.zero_point_out    = data[ZP_W-1:0];
      REG_MULTIPLIER_Q31:    active_cfg.multiplier_q31    = data[MULT_W-1:0];
      REG_SHIFT_AMOUNT:      active_cfg.shift_amount      = data[SHIFT_W-1:0];
      REG_BROADCAST_MODE:    active_cfg.broadcast_mode    = data[0];
      REG_BROADCAST_OPERAND: active_cfg.broadcast_operand = data[ZP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_operands(logic signed [7:0] op_a, logic signed [7:0] op_b,
                               logic typed, logic [ACC_W-1:0] typed_result);
    cfg_ch.valid <= 1'b0;
    while (!no_idle_stretch && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operand_a <= op_a;
    in_ch.operand_b <= op_b;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_products = {pending_products,
                        (typed ? typed_result : requantized_product(op_a, op_b))};
  endtask

  always @(posedge clk_i) begin
    out_ch.ready <= no_idle_stretch || ($urandom_range(99) >= 32);
  end

  always @(posedge clk_i) begin
    logic [ACC_W-1:0] expected_word;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_products.size() == 0) begin
        $error("product_out: no word expected, got %0d", $signed(out_ch.product_out));
        mismatch_count++;
      end else begin
        expected_word = pending_products.pop_front();
        if (out_ch.product_out !== expected_word) begin
          $error("product_out: expected %0d, got %0d",
                 $signed(expected_word), $signed(out_ch.product_out));
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t             row;
    logic [CFG_DATA_W-1:0] value;
    rst_ni          <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operand_a <= '0;
    in_ch.operand_b <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= '0;
    cfg_ch.data     <= '0;
    active_cfg = '0;
    active_cfg.multiplier_q31 = MULT_RESET;

    // With reset settings a product p >= 0 gives (p+1)/2 and a negative p gives (p-1)/2, rounded down.
    directed_rows = '{
      checked_row(0, 0, 0),
      checked_row(127, 127, 8065),
      checked_row(-128, -128, 8192),
      checked_row(-128, 127, -8129),
      checked_row(127, -128, -8129),
      checked_row(1, 1, 1),
      checked_row(-1, 1, -1),
      write_row(REG_ZERO_POINT_OUT, 127),
      write_row(REG_MULTIPLIER_Q31, 0),
      checked_row(-128, -128, 127),
      checked_row(85, -86, 127),
      write_row(REG_MULTIPLIER_Q31, 32'h7FFF_FFFF),
      write_row(REG_ZERO_POINT_A, -128),
      write_row(REG_ZERO_POINT_B, 127),
      write_row(REG_SHIFT_AMOUNT, 15),
      item_row(127, -128),
      item_row(-128, 127),
      item_row(127, 127),
      write_row(REG_SHIFT_AMOUNT, 31),
      item_row(127, -128),
      item_row(-1, 0),
      write_row(REG_SHIFT_AMOUNT, -32),
      item_row(127, -128),
      item_row(-128, -128),
      write_row(REG_SHIFT_AMOUNT, -30),
      write_row(REG_ZERO_POINT_OUT, -128),
      write_row(REG_ZERO_POINT_A, 127),
      write_row(REG_ZERO_POINT_B, -128),
      item_row(-128, 127),
      item_row(0, 0),
      write_row(REG_SHIFT_AMOUNT, -1),
      write_row(REG_MULTIPLIER_Q31, 32'h4000_0000),
      item_row(3, -2),
      write_row(REG_BROADCAST_OPERAND, -128),
      write_row(REG_BROADCAST_MODE, 1),
      item_row(5, 77),
      item_row(-128, 0),
      write_row(REG_UNMAPPED, 32'hFFFF_FFFF),
      item_row(100, -3),
      write_row(REG_BROADCAST_MODE, 0),
      item_row(100, -3)
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) write_register(row.index, row.data);
      else send_operands(row.op_a, row.op_b, row.typed, row.result);
    end

    // The first two phases pin every register to its lowest and highest value.
    for (int phase = 0; phase < PHASES; phase++) begin
      for (int r = int'(REG_ZERO_POINT_A); r <= int'(REG_BROADCAST_OPERAND); r++) begin
        value = $urandom;
        case (cfg_reg_e'(r))
          REG_MULTIPLIER_Q31: begin
            if (phase == 0) value[MULT_W-1:0] = '0;
            else if (phase == 1) value[MULT_W-1:0] = '1;
            else if ($urandom_range(3) == 0) value[MULT_W-1:0] = $urandom_range(1) ? '1 : '0;
          end
          REG_SHIFT_AMOUNT: begin
            if (phase == 0) value[SHIFT_W-1:0] = 6'b100000;
            else if (phase == 1) value[SHIFT_W-1:0] = 6'b011111;
            else if ($urandom_range(3) != 0) value[SHIFT_W-1:0] = 6'($urandom_range(45)) - 6'd30;
          end
          REG_BROADCAST_MODE: begin
            if (phase < 2) value[0] = phase[0];
          end
          default: begin
            if (phase == 0) value[ZP_W-1:0] = 8'h80;
            else if (phase == 1) value[ZP_W-1:0] = 8'h7F;
            else if ($urandom_range(3) == 0) value[ZP_W-1:0] = $urandom_range(1) ? 8'h80 : 8'h7F;
          end
        endcase
        write_register(CFG_IDX_W'(r), value);
      end
      if ($urandom_range(3) == 0) write_register(REG_UNMAPPED, $urandom);
      no_idle_stretch = (phase == STEADY_PHASE);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        send_operands(random_operand(), random_operand(), 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    no_idle_stretch = 1'b0;
    while (pending_products.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("quantized_elementwise_multiply: match");
    end else begin
      $display("quantized_elementwise_multiply: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("quantized_elementwise_multiply: mismatch");
    $finish;
  end

endmodule
